// ===== rtl/drm_pkg.sv =====
// shared types, codes and helpers for the delayed ramp control block
package drm_pkg;

    localparam int VAL_W  = 32;
    localparam int TIME_W = 24;
    localparam int QUO_W  = 33;
    localparam int CNT_W  = 6;
    localparam int PROD_W = VAL_W + TIME_W + 1;
    localparam int STEP_W = PROD_W - 16;
    localparam int SUM_W  = STEP_W + 1;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [VAL_W-1:0]  SLOPE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]  VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SUM,
        S_FIX,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } t_div_rsp;

    // clip a wide signed value into the signed value range
    function automatic logic [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-VAL_W+1){1'b0}}, SLOPE_MAX[VAL_W-2:0]};
        lo = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
        if (x > hi) begin
            sat_val = SLOPE_MAX;
        end else if (x < lo) begin
            sat_val = VAL_MIN;
        end else begin
            sat_val = x[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/drm_div.sv =====
// restoring divider: saturated floor(2^32 / divisor), one quotient bit per cycle
module drm_div import drm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W:0]   r_rem, n_rem;
    logic [TIME_W-1:0] r_div, n_div;
    logic [QUO_W-1:0]  r_quo, n_quo;

    logic              num_bit;
    logic [TIME_W:0]   shifted;
    logic [TIME_W+1:0] trial;
    logic              fits;

    // dividend is a one followed by zeros
    assign num_bit = (r_cnt == '0);
    assign shifted = {r_rem[TIME_W-1:0], num_bit};
    assign trial   = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = !trial[TIME_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? trial[TIME_W:0] : shifted;
            n_quo = {r_quo[QUO_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_quo[QUO_W-1] || r_quo[QUO_W-2]) ? SLOPE_MAX : r_quo[VAL_W-1:0];

endmodule

// ===== rtl/delayed_ramp_control.sv =====
// top level: delayed ramp generator with slew-rate limit and queued targets
// sequence: a tick runs the multiply, shift, sum and fix states before the output state;
//   others go to output; a set or releasing tick that divides a slope first waits in S_DIV
// throughput: one item at a time, next item taken when the sequencer is back in idle,
//   a stalled result holds the sequencer until the output register frees up
// reset: synchronous active low, clears control state, mode register and output valid flag
module delayed_ramp_control import drm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input item channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_action,
    input  logic signed [VAL_W-1:0]  i_target_value,
    input  logic [TIME_W-1:0]        i_ramp_time,
    input  logic [TIME_W-1:0]        i_start_delay,
    input  logic [TIME_W-1:0]        i_elapsed,
    // result item channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [VAL_W-1:0]  o_current_value,
    output logic signed [VAL_W-1:0]  o_last_change,
    output logic                     o_target_waiting,
    // mode register write
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_data
);

    t_state r_state, n_state;

    // architectural state
    logic                     r_block, n_block;
    logic signed [VAL_W-1:0]  r_value, n_value;
    logic signed [VAL_W-1:0]  r_change, n_change;
    logic signed [VAL_W-1:0]  r_goal, n_goal;
    logic signed [VAL_W-1:0]  r_slope, n_slope;
    logic [TIME_W-1:0]        r_wait, n_wait;
    logic [TIME_W-1:0]        r_clock, n_clock;
    logic                     r_pending, n_pending;
    logic signed [VAL_W-1:0]  r_qgoal, n_qgoal;
    logic [TIME_W-1:0]        r_qramp, n_qramp;
    logic [TIME_W-1:0]        r_qwait, n_qwait;

    // tick datapath
    logic [TIME_W-1:0]        r_dt, n_dt;
    logic                     r_ramp_on, n_ramp_on;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [STEP_W-1:0] r_step, n_step;
    logic signed [SUM_W-1:0]  r_nv, n_nv;
    logic                     r_neg, n_neg;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic signed [VAL_W-1:0]  r_out_change, n_out_change;
    logic                     r_out_wait, n_out_wait;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                     in_acc;
    logic [TIME_W:0]          clk_sum;
    logic [TIME_W-1:0]        clk_sat;
    logic signed [PROD_W-1:0] rounded;
    logic signed [SUM_W-1:0]  goal_ext;
    logic signed [SUM_W-1:0]  value_ext;
    logic signed [SUM_W-1:0]  goal_diff;
    logic                     overshoot;
    logic [VAL_W-1:0]         nv_fin;

    // shared target-apply path, fed from the input item or from the queue
    logic                     ap_en;
    logic signed [VAL_W-1:0]  ap_goal;
    logic [TIME_W-1:0]        ap_ramp;
    logic [TIME_W-1:0]        ap_wait;
    logic                     ap_blocked;

    drm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign clk_sum   = {1'b0, r_clock} + {1'b0, i_elapsed};
    assign clk_sat   = clk_sum[TIME_W] ? TIME_MAX : clk_sum[TIME_W-1:0];
    // bias negative products so the shift truncates toward zero
    assign rounded   = r_prod + (r_prod[PROD_W-1] ? PROD_W'(17'h0ffff) : '0);
    assign goal_ext  = SUM_W'(r_goal);
    assign value_ext = SUM_W'(r_value);
    assign goal_diff = goal_ext - value_ext;
    assign overshoot = ((r_slope > 0) && (r_nv > goal_ext))
                    || ((r_slope < 0) && (r_nv < goal_ext));
    // blocking test always looks at the value held before this item
    assign ap_blocked = r_block && (r_value != r_goal);

    always_comb begin
        n_state      = r_state;
        n_block      = r_block;
        n_value      = r_value;
        n_change     = r_change;
        n_goal       = r_goal;
        n_slope      = r_slope;
        n_wait       = r_wait;
        n_clock      = r_clock;
        n_pending    = r_pending;
        n_qgoal      = r_qgoal;
        n_qramp      = r_qramp;
        n_qwait      = r_qwait;
        n_dt         = r_dt;
        n_ramp_on    = r_ramp_on;
        n_prod       = r_prod;
        n_step       = r_step;
        n_nv         = r_nv;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_change = r_out_change;
        n_out_wait   = r_out_wait;
        div_req      = '0;
        ap_en        = 1'b0;
        ap_goal      = i_target_value;
        ap_ramp      = i_ramp_time;
        ap_wait      = i_start_delay;
        nv_fin       = r_value;

        if (i_cfg_valid) begin
            n_block = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_OUT;
                    unique case (i_action)
                        ACT_TICK: begin
                            n_clock   = clk_sat;
                            n_ramp_on = (clk_sat >= r_wait);
                            n_dt      = i_elapsed;
                            n_state   = S_MUL;
                        end
                        ACT_SET: begin
                            ap_en = 1'b1;
                        end
                        ACT_FINISH: begin
                            n_value = r_goal;
                            n_clock = r_wait;
                            n_slope = '0;
                        end
                        default: begin
                            // unused code: report state unchanged
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_prod  = r_slope * $signed({1'b0, r_dt});
                n_state = S_ADD;
            end
            S_ADD: begin
                n_step  = rounded[PROD_W-1:16];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_nv    = value_ext + SUM_W'(r_step);
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_OUT;
                if (!r_ramp_on) begin
                    n_change = '0;
                end else begin
                    if (r_slope == 0) begin
                        nv_fin   = r_goal;
                        n_change = sat_val(goal_diff);
                    end else if (overshoot) begin
                        nv_fin   = r_goal;
                        n_change = sat_val(goal_diff);
                        n_slope  = '0;
                    end else begin
                        nv_fin   = r_nv[VAL_W-1:0];
                        n_change = sat_val(SUM_W'(r_step));
                    end
                    // landing on the goal re-offers a queued target
                    if (r_pending && (nv_fin == r_goal)) begin
                        ap_en   = 1'b1;
                        ap_goal = r_qgoal;
                        ap_ramp = r_qramp;
                        ap_wait = r_qwait;
                    end
                end
                n_value = nv_fin;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_slope = r_neg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_value;
                    n_out_change = r_change;
                    n_out_wait   = r_pending;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // apply or queue a target
        if (ap_en) begin
            if (ap_blocked) begin
                n_pending = 1'b1;
                n_qgoal   = ap_goal;
                n_qramp   = ap_ramp;
                n_qwait   = ap_wait;
            end else begin
                if (r_block) begin
                    n_pending = 1'b0;
                end
                n_goal  = ap_goal;
                n_wait  = ap_wait;
                n_clock = '0;
                if (ap_ramp != '0) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = ap_ramp;
                    n_neg           = (ap_goal < r_value);
                    n_state         = S_DIV;
                end else begin
                    n_slope = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_block     <= 1'b0;
            r_value     <= '0;
            r_change    <= '0;
            r_goal      <= '0;
            r_slope     <= '0;
            r_wait      <= '0;
            r_clock     <= '0;
            r_pending   <= 1'b0;
            r_qgoal     <= '0;
            r_qramp     <= '0;
            r_qwait     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_block     <= n_block;
            r_value     <= n_value;
            r_change    <= n_change;
            r_goal      <= n_goal;
            r_slope     <= n_slope;
            r_wait      <= n_wait;
            r_clock     <= n_clock;
            r_pending   <= n_pending;
            r_qgoal     <= n_qgoal;
            r_qramp     <= n_qramp;
            r_qwait     <= n_qwait;
            r_out_valid <= n_out_valid;
        end
        r_dt         <= n_dt;
        r_ramp_on    <= n_ramp_on;
        r_prod       <= n_prod;
        r_step       <= n_step;
        r_nv         <= n_nv;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_change <= n_out_change;
        r_out_wait   <= n_out_wait;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_current_value  = r_out_value;
    assign o_last_change    = r_out_change;
    assign o_target_waiting = r_out_wait;
    // mode register takes writes at any time
    assign o_cfg_ready      = 1'b1;

endmodule

// ===== rtl/drm_chk.sv =====
// port-level checker for the delayed ramp control block, with its bind
module drm_chk import drm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [VAL_W-1:0] o_current_value,
    input logic signed [VAL_W-1:0] o_last_change,
    input logic                    o_target_waiting
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_current_value)
            && $stable(o_last_change) && $stable(o_target_waiting))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block idle right after taking an item");

    // a new result appears only at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in progress");

    // reset leaves no result and an idle input side
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state left over after reset");

endmodule

bind delayed_ramp_control drm_chk u_drm_chk (.*);
